/* rtl/core/wnp_pkg.sv */
// shared types and constants for the white noise player
package wnp_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VOLUME    = 2'd0;
    localparam logic [1:0] CFG_FULLSCALE = 2'd1;
    localparam logic [1:0] CFG_SPMS      = 2'd2;

    // configuration reset values
    localparam logic [6:0] VOLUME_RST    = 7'd25;
    localparam logic [7:0] FULLSCALE_RST = 8'd255;
    localparam logic [6:0] SPMS_RST      = 7'd8;

    // xorshift32 seed
    localparam logic [31:0] NOISE_SEED = 32'h1234_5678;

    // scaling divisor: 255 full scale times 100 percent
    localparam int          SCALE_DIV = 25500;

    // scaling by reciprocal: drop two low bits (25500 = 4 x 6375), then
    // multiply by ceil(2^34 / 6375) and keep the bits above 34
    localparam int          SCALE_PRE = 2;
    localparam int          SCALE_SH  = 34;
    localparam logic [21:0] SCALE_RCP = 22'd2694882;

    // shared multiplier widths
    localparam int DIV_W   = 23;                // 8 x 8 x 7 bit product
    localparam int MUL_A_W = 21;                // product without two low bits, or window sum
    localparam int MUL_B_W = 22;                // reciprocal
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int TICK_W  = 23;                // 16 bit duration times 7 bit rate

    // largest drive level
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    // input item
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] duration_ms;
    } t_in;

    // result item
    typedef struct packed {
        logic [7:0] level;
        logic       playing;
        logic       finished;
    } t_out;

    // divider request: scaling divide, or window average when by_taps is set
    typedef struct packed {
        logic             start;
        logic             by_taps;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    // divider response
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/core/white_noise_player.sv */
// white noise player: xorshift32 source, volume scaling, moving-average window
// a tick while playing is scaled, then averaged over the window (two passes through
//   the shared reciprocal multiplier); any other item goes straight to its result
// throughput: one item at a time, next item accepted the cycle after the result
//   is taken
// reset: synchronous active low; clears play state and window, reloads seed and config
module white_noise_player #(
    parameter int FILTER_TAPS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wnp_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wnp_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);
    import wnp_pkg::*;

    localparam int POS_W = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int SUM_W = 8 + $clog2(FILTER_TAPS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCALE = 5'b00010,
        ST_DIVT  = 5'b00100,
        ST_DIVA  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [6:0]        r_volume;
    logic [7:0]        r_fullscale;
    logic [6:0]        r_spms;
    logic [31:0]       r_noise, n_noise;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [POS_W-1:0]  r_pos;
    logic              r_active;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [7:0]        r_avg;
    logic [FILTER_TAPS-1:0] r_vld;
    logic [15:0]       r_prod;
    t_out              r_out;

    logic              in_acc;
    logic              is_tick;
    logic [TICK_W-1:0] dur_ticks;
    logic [7:0]        target;
    logic [7:0]        old_smp;
    logic [7:0]        ram_rdata;
    logic              ram_we;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // next noise word
    always_comb begin
        n_noise = r_noise ^ (r_noise << 13);
        n_noise = n_noise ^ (n_noise >> 17);
        n_noise = n_noise ^ (n_noise << 5);
    end

    assign is_tick   = (i_in_data.action == ACT_TICK) && r_active;
    assign dur_ticks = TICK_W'(i_in_data.duration_ms) * TICK_W'(r_spms);

    // saturate the scaled sample and fetch the sample leaving the window
    assign target  = (div_rsp.quotient > DIV_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                            : div_rsp.quotient[7:0];
    assign old_smp = r_vld[r_pos] ? ram_rdata : 8'd0;
    assign n_sum   = r_sum - SUM_W'(old_smp) + SUM_W'(target);
    assign n_ticks = (r_ticks != '0) ? (r_ticks - 1'b1) : r_ticks;
    assign ram_we  = (r_state == ST_DIVT) && div_rsp.done;

    // divider requests: scaling, then window average
    always_comb begin
        div_req.start    = 1'b0;
        div_req.by_taps  = 1'b0;
        div_req.dividend = DIV_W'(r_prod) * DIV_W'(r_volume);
        if (r_state == ST_SCALE) begin
            div_req.start = 1'b1;
        end else if (ram_we) begin
            div_req.start    = 1'b1;
            div_req.by_taps  = 1'b1;
            div_req.dividend = DIV_W'(n_sum);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = is_tick ? ST_SCALE : ST_OUT;
                end
            end
            ST_SCALE: n_state = ST_DIVT;
            ST_DIVT: begin
                if (div_rsp.done) begin
                    n_state = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= VOLUME_RST;
            r_fullscale <= FULLSCALE_RST;
            r_spms      <= SPMS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLUME:    r_volume    <= i_cfg_data[6:0];
                CFG_FULLSCALE: r_fullscale <= i_cfg_data;
                CFG_SPMS:      r_spms      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // play state, generator and window control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_noise  <= NOISE_SEED;
            r_sum    <= '0;
            r_pos    <= '0;
            r_active <= 1'b0;
            r_ticks  <= '0;
            r_avg    <= '0;
            r_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (i_in_data.action)
                    ACT_TICK: begin
                        if (r_active) begin
                            r_noise <= n_noise;
                        end
                    end
                    ACT_START: begin
                        r_active <= 1'b1;
                        if (!r_active || (dur_ticks > r_ticks)) begin
                            r_ticks <= dur_ticks;
                        end
                    end
                    ACT_STOP: begin
                        r_active <= 1'b0;
                        r_ticks  <= '0;
                    end
                    default: ;
                endcase
            end
            // new sample enters the window
            if (ram_we) begin
                r_sum        <= n_sum;
                r_vld[r_pos] <= 1'b1;
                r_pos        <= (r_pos == POS_W'(FILTER_TAPS - 1)) ? '0 : r_pos + 1'b1;
            end
            // average ready: count down play time
            if ((r_state == ST_DIVA) && div_rsp.done) begin
                r_avg   <= div_rsp.quotient[7:0];
                r_ticks <= n_ticks;
                if (n_ticks == '0) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // scaling product and result item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_prod <= 16'(n_noise[7:0]) * 16'(r_fullscale);
            r_out.finished <= 1'b0;
            case (i_in_data.action)
                ACT_TICK: begin
                    r_out.level   <= 8'd0;
                    r_out.playing <= 1'b0;
                end
                ACT_START: begin
                    r_out.level   <= r_avg;
                    r_out.playing <= 1'b1;
                end
                ACT_STOP: begin
                    r_out.level   <= 8'd0;
                    r_out.playing <= 1'b0;
                end
                default: begin
                    r_out.level   <= r_active ? r_avg : 8'd0;
                    r_out.playing <= r_active;
                end
            endcase
        end else if ((r_state == ST_DIVA) && div_rsp.done) begin
            r_out.level    <= (n_ticks == '0) ? 8'd0 : div_rsp.quotient[7:0];
            r_out.playing  <= (n_ticks != '0);
            r_out.finished <= (n_ticks == '0);
        end
    end

    // window sample store
    wnp_ram #(
        .WIDTH (8),
        .DEPTH (FILTER_TAPS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (target),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // shared divider
    wnp_div #(
        .FILTER_TAPS (FILTER_TAPS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

/* rtl/core/wnp_ram.sv */
// generic single-port-write ram with registered read
module wnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/wnp_div.sv */
// constant divider by reciprocal multiplication: operands are captured, then the product is registered as the quotient
module wnp_div #(
    parameter int FILTER_TAPS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wnp_pkg::t_div_req i_req,
    output wnp_pkg::t_div_rsp o_rsp
);
    import wnp_pkg::*;

    // window average reciprocal, exact for every sum below 2^SUM_W
    localparam int SUM_W   = 8 + $clog2(FILTER_TAPS);
    localparam int TAP_SH  = SUM_W + $clog2(FILTER_TAPS);
    localparam int TAP_RCP = ((1 << TAP_SH) + FILTER_TAPS - 1) / FILTER_TAPS;

    logic               r_busy;
    logic               r_done;
    logic               r_by_taps;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_prod;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operand capture, then one pass through the shared multiplier
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_by_taps <= i_req.by_taps;
            if (i_req.by_taps) begin
                r_a <= MUL_A_W'(i_req.dividend);
                r_b <= MUL_B_W'(TAP_RCP);
            end else begin
                r_a <= MUL_A_W'(i_req.dividend >> SCALE_PRE);
                r_b <= SCALE_RCP;
            end
        end else if (r_busy) begin
            r_prod <= MUL_P_W'(r_a) * MUL_P_W'(r_b);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_by_taps ? DIV_W'(r_prod >> TAP_SH) : DIV_W'(r_prod >> SCALE_SH);

endmodule
